[rtl/mma_pkg.sv]
// Shared types and constants for the masked moving average core.
`default_nettype none

package mma_pkg;

    // Width of one range sample and of one average, unsigned Q8.8 metres.
    localparam int DATA_W = 16;

    // Width of the half_width register and its value after reset.
    localparam int HALF_W = 4;
    localparam logic [HALF_W-1:0] HALF_RST = 4'd2;

    // Per-scan sample counter, saturating.
    localparam int SEEN_W = 5;
    localparam logic [SEEN_W-1:0] SEEN_MAX = 5'd31;

    // Default store geometry.
    localparam int MAX_HALF_WIDTH_DEF = 15;
    localparam int DEPTH_DEF = 2 * MAX_HALF_WIDTH_DEF + 1;
    localparam int SUM_W_DEF = DATA_W + $clog2(DEPTH_DEF);
    localparam int CNT_W_DEF = $clog2(DEPTH_DEF + 1);

    // Tag that travels with a window sum toward the divide stage.
    typedef struct packed {
        logic emit;
        logic last;
    } t_res_ctl;

endpackage

`default_nettype wire

[rtl/mma_cell.sv]
// One cell of the prefix chain: holds the sum and count of valid samples up to its offset.
`default_nettype none

module mma_cell #(
    parameter int SUM_W = mma_pkg::SUM_W_DEF,
    parameter int CNT_W = mma_pkg::CNT_W_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_shift,
    input  wire logic                       i_clear,
    input  wire logic [mma_pkg::DATA_W-1:0] i_sample,
    input  wire logic                       i_sample_ok,
    input  wire logic [SUM_W-1:0]           i_prev_sum,
    input  wire logic [CNT_W-1:0]           i_prev_cnt,
    output logic      [SUM_W-1:0]           o_sum,
    output logic      [CNT_W-1:0]           o_cnt
);
    import mma_pkg::*;

    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0] n_cnt;

    // A new sample joins every prefix, so this cell's new prefix is the
    // neighbor's old prefix plus the incoming sample.
    always_comb begin
        n_sum = i_prev_sum + SUM_W'(i_sample);
        n_cnt = i_prev_cnt + CNT_W'(i_sample_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_shift) begin
            r_sum <= n_sum;
            r_cnt <= n_cnt;
        end
    end

    assign o_sum = r_sum;
    assign o_cnt = r_cnt;

endmodule

`default_nettype wire

[rtl/mma_div.sv]
// Divide stage: window sum over valid count by reciprocal multiply, with output register.
`default_nettype none

module mma_div #(
    parameter int SUM_W = mma_pkg::SUM_W_DEF,
    parameter int CNT_W = mma_pkg::CNT_W_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_en,
    input  wire mma_pkg::t_res_ctl          i_ctl,
    input  wire logic [SUM_W-1:0]           i_sum,
    input  wire logic [CNT_W-1:0]           i_cnt,
    output logic                            o_valid,
    output logic      [mma_pkg::DATA_W-1:0] o_avg,
    output logic                            o_avg_ok,
    output logic                            o_last
);
    import mma_pkg::*;

    // Shift of the fixed-point reciprocal. With this many fraction bits the
    // rounded-up reciprocal gives the exact truncated quotient for every sum.
    localparam int K       = SUM_W + CNT_W;
    localparam int RECIP_W = K + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int NUM_REC = 2 ** CNT_W;

    logic [RECIP_W-1:0] w_recip_tab [NUM_REC];

    for (genvar c = 0; c < NUM_REC; c++) begin : g_recip
        localparam longint unsigned DIVISOR   = (c == 0) ? 1 : c;
        localparam longint unsigned RECIP_VAL = (c == 0) ? 0 :
            (((64'd1 << K) + DIVISOR - 1) / DIVISOR);
        assign w_recip_tab[c] = RECIP_W'(RECIP_VAL);
    end

    logic               r_b_valid;
    logic               r_b_last;
    logic               r_b_ok;
    logic [SUM_W-1:0]   r_b_sum;
    logic [RECIP_W-1:0] r_b_recip;

    logic               r_o_valid;
    logic               r_o_last;
    logic               r_o_ok;
    logic [DATA_W-1:0]  r_o_avg;

    logic [PROD_W-1:0]  w_prod;

    // A zero count looks up a zero reciprocal, so the average comes out zero.
    assign w_prod = PROD_W'(r_b_sum) * PROD_W'(r_b_recip);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (i_en) begin
            r_b_valid <= i_ctl.emit;
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_last  <= i_ctl.last;
            r_b_ok    <= (i_cnt != '0);
            r_b_sum   <= i_sum;
            r_b_recip <= w_recip_tab[i_cnt];
            r_o_last  <= r_b_last;
            r_o_ok    <= r_b_ok;
            r_o_avg   <= w_prod[K +: DATA_W];
        end
    end

    assign o_valid  = r_o_valid;
    assign o_avg    = r_o_avg;
    assign o_avg_ok = r_o_ok;
    assign o_last   = r_o_last;

endmodule

`default_nettype wire

[rtl/masked_moving_average_core.sv]
// Top level: centered moving average over a range scan with invalid samples masked out.
// Pipeline: a beat's result passes the prefix cell chain, the divide operand register and the
// output register. Throughput: one ordinary sample per cycle while the output is not stalled;
// a last-of-scan beat then holds input off while half_width padding samples flush the chain and it is cleared.
// Reset: synchronous, active low; empties the chain and the pipeline, half_width returns to 2.
`default_nettype none

module masked_moving_average_core #(
    parameter int MAX_HALF_WIDTH = mma_pkg::MAX_HALF_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration: half_width.
    input  wire logic                         i_cfg_wen,
    input  wire logic [mma_pkg::HALF_W-1:0]   i_cfg_wdata,
    // Sample stream in.
    input  wire logic                         i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire logic [mma_pkg::DATA_W-1:0]   i_s_axis_tdata,   // [15:0] range_sample
    input  wire logic [0:0]                   i_s_axis_tuser,   // [0] sample_finite
    input  wire logic                         i_s_axis_tlast,   // scan_last
    // Average stream out.
    output logic                              o_m_axis_tvalid,
    input  wire logic                         i_m_axis_tready,
    output logic      [mma_pkg::DATA_W-1:0]   o_m_axis_tdata,   // [15:0] average
    output logic      [0:0]                   o_m_axis_tuser,   // [0] average_valid
    output logic                              o_m_axis_tlast    // result_last
);
    import mma_pkg::*;

    // The store is a chain of prefix cells. Cell i holds the sum and count of
    // the valid samples at offsets 0..i, offset 0 being the newest. Shifting
    // a sample in adds it to every prefix and moves each prefix one cell on,
    // so the window at offsets 0..2h is simply the content of cell 2h. This
    // stays correct when half_width changes between beats.
    localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int SUM_W = DATA_W + $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FLUSH,
        ST_CLEAR
    } t_state;

    t_state            r_state;
    t_state            n_state;
    logic [HALF_W-1:0] r_half;
    logic [HALF_W-1:0] r_flush;
    logic [HALF_W-1:0] n_flush;
    logic [SEEN_W-1:0] r_seen;
    logic [SEEN_W-1:0] n_seen;
    t_res_ctl          r_a_ctl;
    t_res_ctl          n_a_ctl;

    logic              w_pipe_en;
    logic              w_accept;
    logic              w_shift;
    logic              w_clear;
    logic              w_x_ok;
    logic [DATA_W-1:0] w_x_range;
    logic [HALF_W-1:0] w_eff_h;
    logic [SEEN_W-1:0] w_seen_inc;
    logic [SEEN_W:0]   w_flush_pos;
    logic [IDX_W-1:0]  w_win_idx;

    logic [SUM_W-1:0]  w_cell_sum [DEPTH];
    logic [CNT_W-1:0]  w_cell_cnt [DEPTH];
    logic [SUM_W-1:0]  w_win_sum;
    logic [CNT_W-1:0]  w_win_cnt;

    logic              w_out_valid;

    // The whole pipeline, chain included, moves only while the output
    // register is empty or being drained; a stall freezes everything.
    assign w_pipe_en       = !w_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE) && w_pipe_en;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // Values above the store's reach are clamped to the largest half width.
    assign w_eff_h = (int'(r_half) > MAX_HALF_WIDTH) ? HALF_W'(MAX_HALF_WIDTH) : r_half;
    assign w_win_idx = IDX_W'({w_eff_h, 1'b0});

    assign w_seen_inc  = (r_seen == SEEN_MAX) ? r_seen : r_seen + 1'b1;
    // Flush step j serves the position h-j, which belongs to the scan when
    // j plus the sample count exceeds h.
    assign w_flush_pos = (SEEN_W + 1)'(r_flush) + (SEEN_W + 1)'(r_seen);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= HALF_RST;
        end else if (i_cfg_wen) begin
            r_half <= i_cfg_wdata;
        end
    end

    // Sequencer. An ordinary beat shifts its sample in and, once more than
    // h samples of the scan are present, asks for the window centered h
    // positions back. A last beat then shifts in h invalid padding samples,
    // one per cycle unless the output stalls, each asking for the next centered
    // window that belongs to the scan, and finally clears the chain for the next scan.
    always_comb begin
        n_state   = r_state;
        n_flush   = r_flush;
        n_seen    = r_seen;
        n_a_ctl   = r_a_ctl;
        w_shift   = 1'b0;
        w_clear   = 1'b0;
        w_x_ok    = 1'b0;
        w_x_range = '0;
        if (w_pipe_en) begin
            n_a_ctl = '{emit: 1'b0, last: 1'b0};
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        w_shift      = 1'b1;
                        w_x_ok       = i_s_axis_tuser[0] && (i_s_axis_tdata != '0);
                        w_x_range    = w_x_ok ? i_s_axis_tdata : '0;
                        n_seen       = w_seen_inc;
                        n_a_ctl.emit = (w_seen_inc > {1'b0, w_eff_h});
                        n_a_ctl.last = i_s_axis_tlast && (w_eff_h == '0);
                        if (i_s_axis_tlast) begin
                            n_flush = HALF_W'(1);
                            n_state = (w_eff_h == '0) ? ST_CLEAR : ST_FLUSH;
                        end
                    end
                end
                ST_FLUSH: begin
                    w_shift      = 1'b1;
                    n_a_ctl.emit = (w_flush_pos > (SEEN_W + 1)'(w_eff_h));
                    n_a_ctl.last = (r_flush == w_eff_h);
                    if (r_flush == w_eff_h) begin
                        n_state = ST_CLEAR;
                    end else begin
                        n_flush = r_flush + 1'b1;
                    end
                end
                ST_CLEAR: begin
                    w_clear = 1'b1;
                    n_seen  = '0;
                    n_state = ST_IDLE;
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_flush <= '0;
            r_seen  <= '0;
            r_a_ctl <= '{emit: 1'b0, last: 1'b0};
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            r_seen  <= n_seen;
            r_a_ctl <= n_a_ctl;
        end
    end

    // Prefix cell chain; cell 0 starts from an empty prefix.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [SUM_W-1:0] w_prev_sum;
        logic [CNT_W-1:0] w_prev_cnt;

        if (i == 0) begin : g_head
            assign w_prev_sum = '0;
            assign w_prev_cnt = '0;
        end else begin : g_link
            assign w_prev_sum = w_cell_sum[i-1];
            assign w_prev_cnt = w_cell_cnt[i-1];
        end

        mma_cell #(
            .SUM_W (SUM_W),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_shift     (w_shift),
            .i_clear     (w_clear),
            .i_sample    (w_x_range),
            .i_sample_ok (w_x_ok),
            .i_prev_sum  (w_prev_sum),
            .i_prev_cnt  (w_prev_cnt),
            .o_sum       (w_cell_sum[i]),
            .o_cnt       (w_cell_cnt[i])
        );
    end

    // The window of the current half width ends at cell 2h.
    assign w_win_sum = w_cell_sum[w_win_idx];
    assign w_win_cnt = w_cell_cnt[w_win_idx];

    mma_div #(
        .SUM_W (SUM_W),
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_pipe_en),
        .i_ctl    (r_a_ctl),
        .i_sum    (w_win_sum),
        .i_cnt    (w_win_cnt),
        .o_valid  (w_out_valid),
        .o_avg    (o_m_axis_tdata),
        .o_avg_ok (o_m_axis_tuser[0]),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tvalid = w_out_valid;

endmodule

`default_nettype wire

[rtl/mma_checker.sv]
// Port-level checker for the masked moving average core, bound to the top level.
`default_nettype none

module mma_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_s_axis_tvalid,
    input wire logic                       o_s_axis_tready,
    input wire logic                       i_s_axis_tlast,
    input wire logic                       o_m_axis_tvalid,
    input wire logic                       i_m_axis_tready,
    input wire logic [mma_pkg::DATA_W-1:0] o_m_axis_tdata,
    input wire logic [0:0]                 o_m_axis_tuser,
    input wire logic                       o_m_axis_tlast
);
    import mma_pkg::*;

    // An empty window must come out as a zero average.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tuser[0]) |-> (o_m_axis_tdata == '0))
        else $error("empty window beat carries a nonzero average");

    // The last beat of a scan starts a flush or, with h zero, the clear, so input is held off next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast) |=> !o_s_axis_tready)
        else $error("input taken right after the last beat of a scan");

    // A stalled output freezes the pipeline, input included.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("input taken while the output is stalled");

    // A pending result stays put until taken.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
             && $stable(o_m_axis_tlast)))
        else $error("stalled output beat changed");

endmodule

bind masked_moving_average_core mma_checker u_mma_checker (.*);

`default_nettype wire
